// ===== sv/lbm_pkg.sv =====
// ----------------------------------------------------------------------------
// lbm_pkg: shared definitions for the 3D label boundary marker
// Widths, volume limits, register and neighborhood codes, and the helpers
// that turn raw register values into clamped "minus one" dimensions.
// ----------------------------------------------------------------------------
package lbm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_DEPTH  = 4096;

  localparam int LABEL_W = 8;
  localparam int X_W     = $clog2(MAX_WIDTH);
  localparam int Y_W     = $clog2(MAX_HEIGHT);
  localparam int Z_W     = $clog2(MAX_DEPTH);
  localparam int PLANE_AW = X_W + Y_W;
  localparam int LAG_W    = PLANE_AW + 1;

  localparam int CFG_XY_W   = 9;
  localparam int CFG_Z_W    = 13;
  localparam int CFG_DATA_W = 13;

  typedef logic [LABEL_W-1:0] label_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DEPTH  = 2'd2,
    REG_CONN   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CONN_6  = 2'd0,
    CONN_18 = 2'd1,
    CONN_26 = 2'd2
  } conn_t;

  // Width register to (width - 1); zero acts as one, oversize as the maximum.
  function automatic logic [X_W-1:0] clamp_x(input logic [CFG_XY_W-1:0] raw);
    if (raw == '0) return '0;
    if (raw > CFG_XY_W'(MAX_WIDTH)) return X_W'(MAX_WIDTH - 1);
    return X_W'(raw - CFG_XY_W'(1));
  endfunction

  function automatic logic [Y_W-1:0] clamp_y(input logic [CFG_XY_W-1:0] raw);
    if (raw == '0) return '0;
    if (raw > CFG_XY_W'(MAX_HEIGHT)) return Y_W'(MAX_HEIGHT - 1);
    return Y_W'(raw - CFG_XY_W'(1));
  endfunction

  function automatic logic [Z_W-1:0] clamp_z(input logic [CFG_Z_W-1:0] raw);
    if (raw == '0) return '0;
    if (raw > CFG_Z_W'(MAX_DEPTH)) return Z_W'(MAX_DEPTH - 1);
    return Z_W'(raw - CFG_Z_W'(1));
  endfunction

endpackage

// ===== sv/label_boundary_marker_3d.sv =====
// ----------------------------------------------------------------------------
// label_boundary_marker_3d: boundary voxel marking for a labeled 3D volume
// Streams voxel labels in raster order and reports, for every voxel, its
// label if a neighbor holds a different nonzero label, plus a running
// bounding box of the boundary voxels.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | word
//  --------+----------------------------+-------------------------------------
//  input   | in_valid / in_stall        | voxel_label, drain
//  output  | out_valid / out_stall      | boundary_label, box_*, last_voxel
//  config  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One input word is taken per cycle while in_stall is low. Once the word
// that completes its neighborhood is taken, a result passes through the
// window stage, loaded with the 3x3x3 window from the line and plane delay
// RAMs, and the output register, which takes the compare and box update.
// In stream terms a voxel's result follows W*H + W + 1 input words after
// the voxel itself; drain words after the volume push the last results out.
// No clearing pass is needed after reset. Input stalls only while both the
// window stage and the output register hold words and the output is stalled.
//
module label_boundary_marker_3d
  import lbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LABEL_W-1:0]    voxel_label,
  input  logic                  drain,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LABEL_W-1:0]    boundary_label,
  output logic                  box_found,
  output logic [X_W-1:0]        box_x_min,
  output logic [Y_W-1:0]        box_y_min,
  output logic [Z_W-1:0]        box_z_min,
  output logic [X_W-1:0]        box_x_max,
  output logic [Y_W-1:0]        box_y_max,
  output logic [Z_W-1:0]        box_z_max,
  output logic                  last_voxel,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration, kept as clamped (dimension - 1) values with the plane
  // size and the fill length worked out at write time.
  logic [X_W-1:0]      w_m1;
  logic [Y_W-1:0]      h_m1;
  logic [Z_W-1:0]      d_m1;
  logic [1:0]          conn;
  logic [PLANE_AW-1:0] wh_m1;
  logic [LAG_W-1:0]    lag;

  logic [X_W-1:0]      w_m1_next;
  logic [Y_W-1:0]      h_m1_next;
  logic [Z_W-1:0]      d_m1_next;
  logic [1:0]          conn_next;
  logic [LAG_W-1:0]    wh_next;

  logic cfg_wr;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    w_m1_next = w_m1;
    h_m1_next = h_m1;
    d_m1_next = d_m1;
    conn_next = conn;
    unique case (cfg_index)
      REG_WIDTH:  w_m1_next = clamp_x(cfg_data[CFG_XY_W-1:0]);
      REG_HEIGHT: h_m1_next = clamp_y(cfg_data[CFG_XY_W-1:0]);
      REG_DEPTH:  d_m1_next = clamp_z(cfg_data[CFG_Z_W-1:0]);
      REG_CONN:   conn_next = cfg_data[1:0];
    endcase
    wh_next = (LAG_W'(w_m1_next) + LAG_W'(1)) * (LAG_W'(h_m1_next) + LAG_W'(1));
  end

  // Stream front end: input position, fill count and output position.
  logic [X_W-1:0]      in_x, out_x;
  logic [Y_W-1:0]      in_y, out_y;
  logic [Z_W-1:0]      in_z, out_z;
  logic                in_done;
  logic [LAG_W-1:0]    fill;
  logic [PLANE_AW-1:0] pa, pa_next;
  logic [X_W-1:0]      ra, ra_next;

  logic accept, advance, wr_voxel, emit, out_last;

  // Window stage and output register.
  logic           a_valid, a_last, move;
  logic [X_W-1:0] a_x;
  logic [Y_W-1:0] a_y;
  logic [Z_W-1:0] a_z;

  assign move     = a_valid && (!out_valid || !out_stall);
  assign in_stall = a_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  // A drain word before the volume is complete is ignored outright; after it,
  // every word (drain or a stray voxel) just shifts the window along.
  assign advance  = accept && (in_done || !drain);
  assign wr_voxel = accept && !in_done && !drain;
  assign emit     = advance && (fill == lag);
  assign out_last = (out_x == w_m1) && (out_y == h_m1) && (out_z == d_m1);
  assign pa_next  = (pa == wh_m1) ? '0 : pa + 1'b1;
  assign ra_next  = (ra == w_m1) ? '0 : ra + 1'b1;

  // Delay RAMs. The plane RAM holds the stream delayed by one and two planes;
  // the row RAM holds each of the three plane streams delayed by one and two
  // rows. The read always points at the next slot to be overwritten, so the
  // old words are on hand when the window advances.
  logic [2*LABEL_W-1:0] plane_rd, plane_wd;
  logic [6*LABEL_W-1:0] row_rd, row_wd;
  label_t               strm [3][3];

  assign plane_wd = {plane_rd[LABEL_W-1:0], voxel_label};

  always_comb begin
    strm[0][0] = voxel_label;
    strm[1][0] = plane_rd[LABEL_W-1:0];
    strm[2][0] = plane_rd[2*LABEL_W-1:LABEL_W];
    for (int k = 0; k < 3; k++) begin
      strm[k][1] = row_rd[k*LABEL_W +: LABEL_W];
      strm[k][2] = row_rd[(3+k)*LABEL_W +: LABEL_W];
    end
    row_wd = {row_rd[3*LABEL_W-1:0], strm[2][0], strm[1][0], strm[0][0]};
  end

  lbm_ram #(.AW(PLANE_AW), .DW(2*LABEL_W)) u_plane_ram (
    .clk   (clk),
    .we    (advance),
    .waddr (pa),
    .wdata (plane_wd),
    .raddr (advance ? pa_next : pa),
    .rdata (plane_rd)
  );

  lbm_ram #(.AW(X_W), .DW(6*LABEL_W)) u_row_ram (
    .clk   (clk),
    .we    (advance),
    .waddr (ra),
    .wdata (row_wd),
    .raddr (advance ? ra_next : ra),
    .rdata (row_rd)
  );

  // 3x3x3 window: win[k][j][i] lies i voxels, j rows and k planes behind the
  // newest word, so the voxel under test is the center entry.
  label_t win [3][3][3];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j][0] <= strm[k][j];
          win[k][j][1] <= win[k][j][0];
          win[k][j][2] <= win[k][j][1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1    <= X_W'(MAX_WIDTH - 1);
      h_m1    <= Y_W'(MAX_HEIGHT - 1);
      d_m1    <= '0;
      conn    <= CONN_26;
      wh_m1   <= PLANE_AW'(MAX_WIDTH * MAX_HEIGHT - 1);
      lag     <= LAG_W'(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
      in_x    <= '0;
      in_y    <= '0;
      in_z    <= '0;
      in_done <= 1'b0;
      fill    <= '0;
      out_x   <= '0;
      out_y   <= '0;
      out_z   <= '0;
      pa      <= '0;
      ra      <= '0;
    end else if (cfg_wr) begin
      w_m1    <= w_m1_next;
      h_m1    <= h_m1_next;
      d_m1    <= d_m1_next;
      conn    <= conn_next;
      wh_m1   <= PLANE_AW'(wh_next - 1'b1);
      lag     <= wh_next + LAG_W'(w_m1_next) + LAG_W'(2);
      in_x    <= '0;
      in_y    <= '0;
      in_z    <= '0;
      in_done <= 1'b0;
      fill    <= '0;
      out_x   <= '0;
      out_y   <= '0;
      out_z   <= '0;
      pa      <= '0;
      ra      <= '0;
    end else begin
      if (advance) begin
        pa <= pa_next;
        ra <= ra_next;
      end
      if (wr_voxel) begin
        if (in_x == w_m1) begin
          in_x <= '0;
          if (in_y == h_m1) begin
            in_y <= '0;
            if (in_z == d_m1) begin
              in_z    <= '0;
              in_done <= 1'b1;
            end else begin
              in_z <= in_z + 1'b1;
            end
          end else begin
            in_y <= in_y + 1'b1;
          end
        end else begin
          in_x <= in_x + 1'b1;
        end
      end
      if (advance && !emit) begin
        fill <= fill + 1'b1;
      end
      if (emit) begin
        if (out_last) begin
          // The volume is finished: the next voxel word starts a new one.
          in_x    <= '0;
          in_y    <= '0;
          in_z    <= '0;
          in_done <= 1'b0;
          fill    <= '0;
          out_x   <= '0;
          out_y   <= '0;
          out_z   <= '0;
        end else if (out_x == w_m1) begin
          out_x <= '0;
          if (out_y == h_m1) begin
            out_y <= '0;
            out_z <= out_z + 1'b1;
          end else begin
            out_y <= out_y + 1'b1;
          end
        end else begin
          out_x <= out_x + 1'b1;
        end
      end
    end
  end

  // Window stage control; the position travels with the window contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= emit;
    end else if (move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      a_x    <= out_x;
      a_y    <= out_y;
      a_z    <= out_z;
      a_last <= out_last;
    end
  end

  // Neighbor compare. An offset is taken when the connectivity admits its
  // number of nonzero axes and the neighbor lies inside the volume.
  label_t center;
  logic   hit, boundary;

  assign center = win[1][1][1];

  always_comb begin
    int   m;
    logic inb;
    label_t nb;
    hit = 1'b0;
    for (int dz = 0; dz < 3; dz++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          m = int'(dx != 1) + int'(dy != 1) + int'(dz != 1);
          inb = !((dx == 0) && (a_x == '0)) && !((dx == 2) && (a_x == w_m1)) &&
                !((dy == 0) && (a_y == '0)) && !((dy == 2) && (a_y == h_m1)) &&
                !((dz == 0) && (a_z == '0)) && !((dz == 2) && (a_z == d_m1));
          nb = win[2-dz][2-dy][2-dx];
          if ((m == 1 || (m == 2 && conn != CONN_6) ||
               (m == 3 && conn != CONN_6 && conn != CONN_18)) &&
              inb && (nb != '0) && (nb != center)) begin
            hit = 1'b1;
          end
        end
      end
    end
  end

  assign boundary = (center != '0) && hit;

  // Running box and output register.
  logic           bb_found, bb_found_next;
  logic [X_W-1:0] bb_x_min, bb_x_max, bb_x_min_next, bb_x_max_next;
  logic [Y_W-1:0] bb_y_min, bb_y_max, bb_y_min_next, bb_y_max_next;
  logic [Z_W-1:0] bb_z_min, bb_z_max, bb_z_min_next, bb_z_max_next;

  always_comb begin
    bb_found_next = bb_found;
    bb_x_min_next = bb_x_min;
    bb_y_min_next = bb_y_min;
    bb_z_min_next = bb_z_min;
    bb_x_max_next = bb_x_max;
    bb_y_max_next = bb_y_max;
    bb_z_max_next = bb_z_max;
    if (boundary) begin
      bb_found_next = 1'b1;
      if (!bb_found || a_x < bb_x_min) bb_x_min_next = a_x;
      if (!bb_found || a_y < bb_y_min) bb_y_min_next = a_y;
      if (!bb_found || a_z < bb_z_min) bb_z_min_next = a_z;
      if (!bb_found || a_x > bb_x_max) bb_x_max_next = a_x;
      if (!bb_found || a_y > bb_y_max) bb_y_max_next = a_y;
      if (!bb_found || a_z > bb_z_max) bb_z_max_next = a_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr || (move && a_last)) begin
      bb_found <= 1'b0;
      bb_x_min <= '0;
      bb_y_min <= '0;
      bb_z_min <= '0;
      bb_x_max <= '0;
      bb_y_max <= '0;
      bb_z_max <= '0;
    end else if (move) begin
      bb_found <= bb_found_next;
      bb_x_min <= bb_x_min_next;
      bb_y_min <= bb_y_min_next;
      bb_z_min <= bb_z_min_next;
      bb_x_max <= bb_x_max_next;
      bb_y_max <= bb_y_max_next;
      bb_z_max <= bb_z_max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      boundary_label <= boundary ? center : '0;
      box_found      <= bb_found_next;
      box_x_min      <= bb_x_min_next;
      box_y_min      <= bb_y_min_next;
      box_z_min      <= bb_z_min_next;
      box_x_max      <= bb_x_max_next;
      box_y_max      <= bb_y_max_next;
      box_z_max      <= bb_z_max_next;
      last_voxel     <= a_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (a_valid && out_valid && out_stall) |=> a_valid)
    else $error("window stage word dropped while output stalled");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= lag)
    else $error("fill count ran past the stream lag");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && box_found) |->
      (box_x_min <= box_x_max && box_y_min <= box_y_max && box_z_min <= box_z_max))
    else $error("bounding box minimum above maximum");

  a_box_clear: assert property (@(posedge clk) disable iff (rst)
    (move && a_last) |=> !bb_found)
    else $error("box not cleared after the last voxel");

  a_no_emit_early: assert property (@(posedge clk) disable iff (rst)
    (advance && fill != lag) |=> !a_valid)
    else $error("result produced before the window was full");
`endif

endmodule

// ===== sv/lbm_ram.sv =====
// ----------------------------------------------------------------------------
// lbm_ram: simple dual-port RAM with registered read
// One write and one read per cycle; a read of the address being written
// returns the new word.
// ----------------------------------------------------------------------------
module lbm_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
